>>> rtl/swir_pkg.sv
// Package for the sorted window insert/replace block.
// Holds the window size, shared types and codes. Depends on nothing.
package swir_pkg;

  // Window geometry.
  localparam int unsigned Window = 64;
  localparam int unsigned IdxW   = $clog2(Window);
  localparam int unsigned CntW   = $clog2(Window + 1);

  typedef logic signed [31:0] value_t;

  // Operation of one transaction, decided when it is taken in.
  typedef enum logic [1:0] {
    MODE_INSERT,
    MODE_DOWN,
    MODE_UP,
    MODE_EQUAL
  } mode_e;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FULL    = 2'd1,
    STATUS_MISSING = 2'd2
  } status_e;

  // Compare flags that each cell registers and shows to its neighbors.
  typedef struct packed {
    logic vld;
    logic lt_new;
    logic le_new;
    logic lt_old;
    logic le_old;
  } flags_t;

  // Control broadcast from the sequencer to every cell.
  typedef struct packed {
    logic  cmp_en;
    logic  upd_en;
    mode_e mode;
  } ctrl_t;

  // Position markers that a cell reports back.
  typedef struct packed {
    logic p;
    logic q;
    logic hit;
  } mark_t;

endpackage

>>> rtl/sorted_window_insert_replace.sv
// Top level of the sorted window insert/replace block: sequencer and cell chain.
// Depends on swir_pkg and swir_cell.
//
//   Channel | Handshake              | Payload
//   --------+------------------------+---------------------------------------------
//   input   | in_valid_i, in_ready_o | func_i, new_value_i, old_value_i
//   output  | out_valid_o,out_ready_i| new_pos_o, old_pos_o, status_o, fill_count_o
//
// Each transaction passes take-in, a compare step in which every
// cell registers its flags, and an update step in which the cells shift by one
// and the result register is loaded. The next transaction is taken the cycle
// after the update; a new one is never taken before the last is through.
// Reset empties the window at once; no clearing pass is needed.
// A result that is not taken holds the block in its compare cycle.
module sorted_window_insert_replace (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 func_i,
  input  logic signed [31:0]   new_value_i,
  input  logic signed [31:0]   old_value_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic        [5:0]    new_pos_o,
  output logic        [5:0]    old_pos_o,
  output logic        [1:0]    status_o,
  output logic        [6:0]    fill_count_o
);
  import swir_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  state_e            state_q;
  mode_e             mode_q;
  value_t            new_q;
  value_t            old_q;
  logic [CntW-1:0]   count_q, count_d;
  logic              out_valid_q;
  logic [5:0]        new_pos_q;
  logic [5:0]        old_pos_q;
  status_e           status_q;
  logic [6:0]        fill_q;

  ctrl_t             ctrl;
  value_t            entry [Window];
  flags_t            flags [Window];
  mark_t             mark  [Window];

  logic [IdxW-1:0]   p_pos;
  logic [IdxW-1:0]   q_pos;
  logic              found;
  logic              full;
  logic              ok;
  logic [IdxW-1:0]   res_new_pos;
  logic [IdxW-1:0]   res_old_pos;
  status_e           res_status;
  logic              out_free;
  mode_e             mode_d;

  // Operation of an incoming transaction.
  always_comb begin
    if (!func_i) begin
      mode_d = MODE_INSERT;
    end else if (new_value_i < old_value_i) begin
      mode_d = MODE_DOWN;
    end else if (new_value_i > old_value_i) begin
      mode_d = MODE_UP;
    end else begin
      mode_d = MODE_EQUAL;
    end
  end

  // Encode the one-hot position markers coming back from the cells.
  always_comb begin
    p_pos = '0;
    q_pos = '0;
    found = 1'b0;
    for (int k = 0; k < Window; k++) begin
      if (mark[k].p) begin
        p_pos = p_pos | IdxW'(k);
      end
      if (mark[k].q) begin
        q_pos = q_pos | IdxW'(k);
      end
      found = found | mark[k].hit;
    end
  end

  // Result of the transaction in the update cycle.
  always_comb begin
    full        = (count_q >= CntW'(Window));
    ok          = 1'b0;
    res_new_pos = '0;
    res_old_pos = '0;
    res_status  = STATUS_OK;
    case (mode_q)
      MODE_INSERT: begin
        ok          = !full;
        res_new_pos = p_pos;
        res_old_pos = p_pos;
      end
      MODE_DOWN, MODE_UP: begin
        ok          = found;
        res_new_pos = p_pos;
        res_old_pos = q_pos;
      end
      MODE_EQUAL: begin
        ok          = found;
        res_new_pos = q_pos;
        res_old_pos = q_pos;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
    if (!ok) begin
      res_new_pos = '0;
      res_old_pos = '0;
      res_status  = (mode_q == MODE_INSERT) ? STATUS_FULL : STATUS_MISSING;
    end
  end

  // Fill count grows only on a successful insert.
  always_comb begin
    count_d = count_q;
    if (state_q == ST_UPD && mode_q == MODE_INSERT && ok) begin
      count_d = count_q + CntW'(1);
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // Broadcast control to the cell chain.
  always_comb begin
    ctrl.cmp_en = (state_q == ST_CMP);
    ctrl.upd_en = (state_q == ST_UPD) && ok;
    ctrl.mode   = mode_q;
  end

  // Chain of cells, each wired to its neighbors; the end cells see constants instead.
  for (genvar k = 0; k < Window; k++) begin : g_cell
    flags_t lf, rf;
    value_t le, re;

    if (k == 0) begin : g_first
      assign lf = '1;
      assign le = '0;
    end else begin : g_mid_l
      assign lf = flags[k-1];
      assign le = entry[k-1];
    end

    if (k == Window - 1) begin : g_last
      assign rf = '0;
      assign re = '0;
    end else begin : g_mid_r
      assign rf = flags[k+1];
      assign re = entry[k+1];
    end

    swir_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .in_range_i    (count_q > CntW'(k)),
      .new_value_i   (new_q),
      .old_value_i   (old_q),
      .left_flags_i  (lf),
      .right_flags_i (rf),
      .left_entry_i  (le),
      .right_entry_i (re),
      .entry_o       (entry[k]),
      .flags_o       (flags[k]),
      .mark_o        (mark[k])
    );
  end

  // Sequencer, operands, fill count and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      mode_q      <= MODE_INSERT;
    end else begin
      count_q <= count_d;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            mode_q  <= mode_d;
            new_q   <= new_value_i;
            old_q   <= old_value_i;
            state_q <= ST_CMP;
          end
        end
        ST_CMP: begin
          if (out_free) begin
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          new_pos_q <= 6'(res_new_pos);
          old_pos_q <= 6'(res_old_pos);
          status_q  <= res_status;
          fill_q    <= 7'(count_d);
          state_q   <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (state_q == ST_UPD) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign in_ready_o   = (state_q == ST_IDLE);
  assign out_valid_o  = out_valid_q;
  assign new_pos_o    = new_pos_q;
  assign old_pos_o    = old_pos_q;
  assign status_o     = status_q;
  assign fill_count_o = fill_q;

endmodule

>>> rtl/swir_cell.sv
// One window cell: holds one entry and its compare flags.
// Depends on swir_pkg.
module swir_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  swir_pkg::ctrl_t  ctrl_i,
  input  logic            in_range_i,
  input  swir_pkg::value_t new_value_i,
  input  swir_pkg::value_t old_value_i,
  input  swir_pkg::flags_t left_flags_i,
  input  swir_pkg::flags_t right_flags_i,
  input  swir_pkg::value_t left_entry_i,
  input  swir_pkg::value_t right_entry_i,
  output swir_pkg::value_t entry_o,
  output swir_pkg::flags_t flags_o,
  output swir_pkg::mark_t  mark_o
);
  import swir_pkg::*;

  value_t entry_q, entry_d;
  flags_t flags_q, flags_d;
  mark_t  mark;
  logic   take_left;
  logic   take_right;

  // Compare the stored entry against both broadcast values.
  always_comb begin
    flags_d.vld    = in_range_i;
    flags_d.lt_new = in_range_i && (entry_q <  new_value_i);
    flags_d.le_new = in_range_i && (entry_q <= new_value_i);
    flags_d.lt_old = in_range_i && (entry_q <  old_value_i);
    flags_d.le_old = in_range_i && (entry_q <= old_value_i);
  end

  // Locate the new and old positions from this cell's and its neighbors' flags.
  // The flags form thermometer codes because the window is sorted.
  always_comb begin
    mark = '0;
    case (ctrl_i.mode)
      MODE_UP: begin
        mark.p = flags_q.le_new && !right_flags_i.le_new;
        mark.q = flags_q.le_old && !right_flags_i.le_old;
      end
      default: begin
        mark.p = !flags_q.lt_new && left_flags_i.lt_new;
        mark.q = !flags_q.lt_old && left_flags_i.lt_old;
      end
    endcase
    mark.hit = mark.q && flags_q.le_old && !flags_q.lt_old;
  end

  // Shift conditions toward the neighbor on each side.
  always_comb begin
    take_left  = 1'b0;
    take_right = 1'b0;
    case (ctrl_i.mode)
      MODE_INSERT: take_left  = left_flags_i.vld && !left_flags_i.lt_new;
      MODE_DOWN:   take_left  = !left_flags_i.lt_new && left_flags_i.lt_old;
      MODE_UP:     take_right = right_flags_i.le_new && !right_flags_i.le_old;
      default: begin
        take_left  = 1'b0;
        take_right = 1'b0;
      end
    endcase
  end

  // Next entry: the new value at its position, otherwise a neighbor's entry on a shift, else kept.
  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.mode != MODE_EQUAL) begin
      if (mark.p) begin
        entry_d = new_value_i;
      end else if (take_left) begin
        entry_d = left_entry_i;
      end else if (take_right) begin
        entry_d = right_entry_i;
      end
    end
  end

  // Flags are captured in the compare cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
    end else if (ctrl_i.cmp_en) begin
      flags_q <= flags_d;
    end
  end

  // The entry changes only in an update cycle that succeeds.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.upd_en) begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;
  assign flags_o = flags_q;
  assign mark_o  = mark;

endmodule
